/* hdl/wrr_sel_pkg.sv */
// Shared types, constants and helpers for the weighted round robin selector.
// No dependencies; imported by the controller, the datapath and the top level.
package wrr_sel_pkg;

    localparam int DEF_MAX_INSTANCES = 8;
    localparam int DEF_WEIGHT_BITS   = 8;
    localparam int DEF_COUNTER_BITS  = 32;

    localparam int CNT_W       = 4;
    localparam int IDX_OUT_W   = 3;
    localparam int TABLE_W     = 64;
    localparam int SEED_W      = 32;
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 2;
    localparam int TDATA_W     = 8;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE        = 2'd0,
        REG_USE_WEIGHTS = 2'd1,
        REG_WEIGHTS     = 2'd2,
        REG_SEED        = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_RR         = 2'd0,
        MODE_WRR        = 2'd1,
        MODE_RANDOM     = 2'd2,
        MODE_LEAST_CONN = 2'd3
    } sel_mode_t;

    typedef enum logic [1:0] {
        RES_KEEP = 2'd0,
        RES_NONE = 2'd1,
        RES_REM  = 2'd2,
        RES_SCAN = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     sum_step;
        logic     div_step;
        logic     scan_step;
        res_sel_t res;
        logic     finish;
    } wrr_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic sel_random;
        logic sel_weighted;
        logic weighted;
        logic step_last;
        logic sum_zero;
        logic div_last;
        logic scan_hit;
        logic out_free;
    } wrr_status_t;

    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] v;
        v = (s == '0) ? SEED_W'(1) : s;
        return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage

/* hdl/wrr_sel_ctrl.sv */
// Sequencing FSM of the selector: accept, weight sum, remainder, span scan, output.
// Depends on wrr_sel_pkg; drives wrr_sel_dp through wrr_cmd_t.
module wrr_sel_ctrl
    import wrr_sel_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  wrr_status_t status,
    output wrr_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (status.count_zero) begin
                        cmd.res    = RES_NONE;
                        state_next = ST_DONE;
                    end else if (status.sel_random) begin
                        state_next = ST_DIV;
                    end else if (status.sel_weighted) begin
                        state_next = ST_SUM;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (status.step_last) begin
                    if (status.sum_zero) begin
                        cmd.res    = RES_NONE;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    if (status.weighted) begin
                        state_next = ST_SCAN;
                    end else begin
                        cmd.res    = RES_REM;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_hit) begin
                    cmd.res    = RES_SCAN;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/wrr_sel_dp.sv */
// Datapath: config registers, rotation counter, LFSR, weight accumulator,
// restoring remainder unit and output register. Depends on wrr_sel_pkg.
module wrr_sel_dp
    import wrr_sel_pkg::*;
#(
    parameter int MAX_INSTANCES = DEF_MAX_INSTANCES,
    parameter int WEIGHT_BITS   = DEF_WEIGHT_BITS,
    parameter int COUNTER_BITS  = DEF_COUNTER_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [CNT_W-1:0]      in_count,
    input  wrr_cmd_t              cmd,
    output wrr_status_t           status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [IDX_OUT_W-1:0]  out_index,
    output logic                  out_found
);

    localparam int SUM_W = WEIGHT_BITS + CNT_W;
    localparam int IDX_W = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int CAP   = (MAX_INSTANCES > 15) ? 15 : MAX_INSTANCES;

    function automatic logic [TABLE_W-1:0] weight_reset();
        logic [TABLE_W-1:0] v;
        v = '0;
        for (int k = 0; k < TABLE_W; k += WEIGHT_BITS) begin
            v[k] = 1'b1;
        end
        return v;
    endfunction

    localparam logic [TABLE_W-1:0] WEIGHT_RESET = weight_reset();

    sel_mode_t              mode_reg;
    logic                   use_weights_reg;
    logic [TABLE_W-1:0]     weight_table_reg;
    logic [SEED_W-1:0]      lfsr_reg;
    logic [COUNTER_BITS-1:0] counter_reg;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       step_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       divisor_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [DIV_W-1:0]       dividend_reg;
    logic [DIV_CNT_W-1:0]   bit_cnt_reg;
    logic                   weighted_reg;
    logic                   inc_reg;
    logic [IDX_OUT_W-1:0]   res_idx_reg;
    logic                   res_found_reg;
    logic                   m_tvalid_reg;
    logic [IDX_OUT_W-1:0]   m_index_reg;
    logic                   m_found_reg;

    // per-instance weights; slots past the table weigh one
    logic [TABLE_W+WEIGHT_BITS-1:0] table_pad;
    logic [WEIGHT_BITS-1:0]         weight_arr [MAX_INSTANCES];

    assign table_pad = {{WEIGHT_BITS{1'b0}}, weight_table_reg};

    for (genvar g = 0; g < MAX_INSTANCES; g++) begin : g_weight
        if (g * WEIGHT_BITS < TABLE_W) begin : g_in
            assign weight_arr[g] = table_pad[g*WEIGHT_BITS +: WEIGHT_BITS];
        end else begin : g_out
            assign weight_arr[g] = WEIGHT_BITS'(1);
        end
    end

    logic [CNT_W-1:0]  count_sat;
    logic              sel_random;
    logic [SEED_W-1:0] lfsr_adv;
    logic [SUM_W-1:0]  acc_next;
    logic              step_last;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;
    logic [SUM_W-1:0]  rem_next;

    assign count_sat  = (in_count > CNT_W'(CAP)) ? CNT_W'(CAP) : in_count;
    assign sel_random = (mode_reg == MODE_RANDOM);
    assign lfsr_adv   = lfsr_next(lfsr_reg);
    assign acc_next   = acc_reg + SUM_W'(weight_arr[step_reg[IDX_W-1:0]]);
    assign step_last  = (step_reg == count_reg - CNT_W'(1));
    assign trial      = {rem_reg, dividend_reg[DIV_W-1]};
    assign diff       = trial - {1'b0, divisor_reg};
    assign rem_next   = diff[SUM_W] ? trial[SUM_W-1:0] : diff[SUM_W-1:0];

    always_comb begin
        status              = '0;
        status.count_zero   = (count_sat == '0);
        status.sel_random   = sel_random;
        status.sel_weighted = (mode_reg == MODE_WRR) && use_weights_reg;
        status.weighted     = weighted_reg;
        status.step_last    = step_last;
        status.sum_zero     = (acc_next == '0);
        status.div_last     = (bit_cnt_reg == DIV_CNT_W'(DIV_W - 1));
        status.scan_hit     = (rem_reg < acc_next);
        status.out_free     = !m_tvalid_reg || m_tready;
    end

    // config, counter, LFSR and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_RR;
            use_weights_reg  <= 1'b0;
            weight_table_reg <= WEIGHT_RESET;
            lfsr_reg         <= SEED_W'(1);
            counter_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_MODE:        mode_reg         <= sel_mode_t'(cfg_wdata[1:0]);
                    REG_USE_WEIGHTS: use_weights_reg  <= cfg_wdata[0];
                    REG_WEIGHTS:     weight_table_reg <= cfg_wdata[TABLE_W-1:0];
                    REG_SEED:        lfsr_reg         <= cfg_wdata[SEED_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load && sel_random && count_sat != '0) begin
                lfsr_reg <= lfsr_adv;
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
                if (res_found_reg && inc_reg) begin
                    counter_reg <= counter_reg + COUNTER_BITS'(1);
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            count_reg    <= count_sat;
            step_reg     <= '0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            bit_cnt_reg  <= '0;
            divisor_reg  <= SUM_W'(count_sat);
            dividend_reg <= sel_random ? DIV_W'(lfsr_adv) : DIV_W'(counter_reg);
            weighted_reg <= (mode_reg == MODE_WRR) && use_weights_reg;
            inc_reg      <= !sel_random;
        end
        if (cmd.sum_step) begin
            if (step_last) begin
                divisor_reg <= acc_next;
                acc_reg     <= '0;
                step_reg    <= '0;
            end else begin
                acc_reg  <= acc_next;
                step_reg <= step_reg + CNT_W'(1);
            end
        end
        if (cmd.div_step) begin
            rem_reg      <= rem_next;
            dividend_reg <= {dividend_reg[DIV_W-2:0], 1'b0};
            bit_cnt_reg  <= bit_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.scan_step) begin
            acc_reg  <= acc_next;
            step_reg <= step_reg + CNT_W'(1);
        end
        case (cmd.res)
            RES_NONE: begin
                res_idx_reg   <= '0;
                res_found_reg <= 1'b0;
            end
            RES_REM: begin
                // taken on the last remainder step
                res_idx_reg   <= rem_next[IDX_OUT_W-1:0];
                res_found_reg <= 1'b1;
            end
            RES_SCAN: begin
                res_idx_reg   <= step_reg[IDX_OUT_W-1:0];
                res_found_reg <= 1'b1;
            end
            default: ;
        endcase
        if (cmd.finish) begin
            m_index_reg <= res_idx_reg;
            m_found_reg <= res_found_reg;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign out_index = m_index_reg;
    assign out_found = m_found_reg;

endmodule

/* hdl/weighted_round_robin_selector.sv */
// Weighted round robin selector, top level: wires the FSM to the datapath.
// Depends on wrr_sel_pkg, wrr_sel_ctrl and wrr_sel_dp.
// Sequence from accepted word to valid result: for round robin and random, the
// bit-serial remainder unit runs over the dividend, then the result is registered;
// weighted mode runs the weight sum before the remainder and the span scan after it.
// An empty list or a zero weight sum skips straight to the result.
// One word in flight; the next is taken the cycle after the result is registered,
// and a stalled result holds off the input.
// Reset (aresetn low, synchronous) restores config, valid, counter 0, LFSR 1.
module weighted_round_robin_selector
    import wrr_sel_pkg::*;
#(
    parameter int MAX_INSTANCES = DEF_MAX_INSTANCES,
    parameter int WEIGHT_BITS   = DEF_WEIGHT_BITS,
    parameter int COUNTER_BITS  = DEF_COUNTER_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // [3:0] instance_count
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata    // [2:0] selected_index, [3] found
);

    wrr_cmd_t             cmd;
    wrr_status_t          status;
    logic [IDX_OUT_W-1:0] out_index;
    logic                 out_found;

    wrr_sel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wrr_sel_dp #(
        .MAX_INSTANCES (MAX_INSTANCES),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_count  (s_tdata[CNT_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_index (out_index),
        .out_found (out_found)
    );

    assign m_tdata = {{(TDATA_W-IDX_OUT_W-1){1'b0}}, out_found, out_index};

endmodule
